// ===== design/amtu_pkg.sv =====
// shared types and codes for the affine matrix transform unit
`default_nettype none
package amtu_pkg;

  localparam int unsigned LANES    = 4;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STEP_W   = 4;
  localparam logic [STEP_W-1:0] STEP_MATRIX_LAST = 4'd15;
  localparam logic [STEP_W-1:0] STEP_XFORM_LAST  = 4'd3;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

  typedef enum logic [2:0] {
    FN_LOAD_CUR   = 3'd0,
    FN_LOAD_OPND  = 3'd1,
    FN_IDENTITY   = 3'd2,
    FN_MULTIPLY   = 3'd3,
    FN_TRANSLATE  = 3'd4,
    FN_SCALE      = 3'd5,
    FN_POINT      = 3'd6,
    FN_VECTOR     = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic       load;
    logic [1:0] load_row;
    logic [1:0] load_col;
    logic       ident;
    logic       commit;
    logic       mac_valid;
    logic       first_k;
    logic       first_item;
    logic       last_k;
    logic [1:0] k;
    logic [1:0] col;
  } lane_ctrl_t;

  typedef struct packed {
    logic push;
    logic xform;
    logic mac;
  } merge_ctrl_t;

endpackage
`default_nettype wire

// ===== design/amtu_lane.sv =====
// one row lane: row storage of the current matrix and a saturating fixed-point mac
`default_nettype none
module amtu_lane
  import amtu_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned ROW       = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire lane_ctrl_t               ctrl,
  input  wire logic signed [WORD_W-1:0] load_value,
  input  wire logic signed [WORD_W-1:0] one_value,
  input  wire logic signed [WORD_W-1:0] rhs,
  output logic signed [WORD_W-1:0]      acc,
  output logic                          ovf
);

  localparam logic [1:0] ROW_IDX = ROW[1:0];

  logic signed [WORD_W-1:0]   cur_row [LANES];
  logic signed [WORD_W-1:0]   tmp_row [LANES];
  logic signed [2*WORD_W-1:0] prod;
  logic                       p_valid;
  logic                       p_first_k;
  logic                       p_first_item;
  logic                       p_last_k;
  logic [1:0]                 p_col;

  logic signed [2*WORD_W-1:0] shifted;
  logic                       mul_sat;
  logic signed [WORD_W-1:0]   mq;
  logic signed [WORD_W:0]     s33;
  logic                       add_sat;
  logic signed [WORD_W-1:0]   sum;

  // row storage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) cur_row[i] <= '0;
    end else if (ctrl.ident) begin
      for (int i = 0; i < LANES; i++) cur_row[i] <= (i == ROW) ? one_value : '0;
    end else if (ctrl.load && ctrl.load_row == ROW_IDX) begin
      cur_row[ctrl.load_col] <= load_value;
    end else if (ctrl.commit) begin
      for (int i = 0; i < LANES; i++) cur_row[i] <= tmp_row[i];
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= ctrl.mac_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod         <= cur_row[ctrl.k] * rhs;
    p_first_k    <= ctrl.first_k;
    p_first_item <= ctrl.first_item;
    p_last_k     <= ctrl.last_k;
    p_col        <= ctrl.col;
  end

  // scale, clamp and accumulate
  always_comb begin
    shifted = prod >>> FRAC_BITS;
    mul_sat = !((&shifted[2*WORD_W-1:WORD_W-1]) || !(|shifted[2*WORD_W-1:WORD_W-1]));
    if (mul_sat) begin
      mq = shifted[2*WORD_W-1] ? WORD_MIN : WORD_MAX;
    end else begin
      mq = shifted[WORD_W-1:0];
    end
    s33     = {acc[WORD_W-1], acc} + {mq[WORD_W-1], mq};
    add_sat = 1'b0;
    if (p_first_k) begin
      sum = mq;
    end else begin
      add_sat = s33[WORD_W] ^ s33[WORD_W-1];
      if (add_sat) begin
        sum = s33[WORD_W] ? WORD_MIN : WORD_MAX;
      end else begin
        sum = s33[WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      acc <= sum;
      ovf <= (p_first_item ? 1'b0 : ovf) | mul_sat | add_sat;
      if (p_last_k) tmp_row[p_col] <= sum;
    end
  end

endmodule
`default_nettype wire

// ===== design/amtu_merge.sv =====
// merging stage: gathers lane results into the output register
`default_nettype none
module amtu_merge
  import amtu_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire merge_ctrl_t              ctrl,
  input  wire logic signed [WORD_W-1:0] lane_acc [LANES],
  input  wire logic [LANES-1:0]         lane_ovf,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic                          can_load,
  output logic signed [WORD_W-1:0]      res_x,
  output logic signed [WORD_W-1:0]      res_y,
  output logic signed [WORD_W-1:0]      res_z,
  output logic                          overflow
);

  logic ovf_any;

  assign can_load = !out_valid || out_ready;

  // the fourth lane only counts for matrix updates
  always_comb begin
    if (!ctrl.mac) begin
      ovf_any = 1'b0;
    end else if (ctrl.xform) begin
      ovf_any = |lane_ovf[2:0];
    end else begin
      ovf_any = |lane_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      res_x    <= ctrl.xform ? lane_acc[0] : '0;
      res_y    <= ctrl.xform ? lane_acc[1] : '0;
      res_z    <= ctrl.xform ? lane_acc[2] : '0;
      overflow <= ovf_any;
    end
  end

endmodule
`default_nettype wire

// ===== design/affine_matrix_transform_unit.sv =====
// Loads and identity go from accept straight to the push state; point and vector
// transforms and matrix multiply, translate and scale run, wait to drain, then push.
// A new transaction is accepted only in idle, after the last one is pushed; each of
// the four row lanes takes 4 or 16 steps through its mac, and a full output stalls push.
// Reset clears both matrices, the sequencer and the output valid flag.
// top level: sequencer, operand matrix, four row lanes and the merging stage
`default_nettype none
module affine_matrix_transform_unit
  import amtu_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               func,
  input  wire logic [3:0]               element_index,
  input  wire logic signed [WORD_W-1:0] element_value,
  input  wire logic signed [WORD_W-1:0] coord_x,
  input  wire logic signed [WORD_W-1:0] coord_y,
  input  wire logic signed [WORD_W-1:0] coord_z,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [WORD_W-1:0]      res_x,
  output logic signed [WORD_W-1:0]      res_y,
  output logic signed [WORD_W-1:0]      res_z,
  output logic                          overflow
);

  localparam logic signed [WORD_W-1:0] ONE = WORD_W'(64'd1 << FRAC_BITS);

  state_t                   state;
  state_t                   state_next;
  logic [STEP_W-1:0]        step;
  logic [STEP_W-1:0]        last_step;
  func_t                    func_q;
  func_t                    func_in;
  logic signed [WORD_W-1:0] x_q;
  logic signed [WORD_W-1:0] y_q;
  logic signed [WORD_W-1:0] z_q;
  logic signed [WORD_W-1:0] opnd [16];
  logic signed [WORD_W-1:0] rhs;
  logic                     accept;
  logic                     is_mac;
  logic                     is_xform;
  logic                     is_matrix;
  logic                     can_load;
  lane_ctrl_t               lane_ctrl;
  merge_ctrl_t              merge_ctrl;
  logic signed [WORD_W-1:0] lane_acc [LANES];
  logic [LANES-1:0]         lane_ovf;
  logic [1:0]               col;
  logic [1:0]               k;

  assign func_in   = func_t'(func);
  assign accept    = in_valid && in_ready;
  assign is_xform  = (func_q == FN_POINT) || (func_q == FN_VECTOR);
  assign is_matrix = (func_q == FN_MULTIPLY) || (func_q == FN_TRANSLATE) ||
                     (func_q == FN_SCALE);
  assign is_mac    = is_xform || is_matrix;
  assign last_step = is_matrix ? STEP_MATRIX_LAST : STEP_XFORM_LAST;
  assign col       = step[3:2];
  assign k         = step[1:0];

  // transaction capture and operand matrix
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func_in;
      x_q    <= coord_x;
      y_q    <= coord_y;
      z_q    <= coord_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) opnd[i] <= '0;
    end else if (accept && func_in == FN_LOAD_OPND) begin
      opnd[element_index] <= element_value;
    end
  end

  // right-hand element for the current step
  always_comb begin
    rhs = '0;
    case (func_q)
      FN_MULTIPLY: rhs = opnd[step];
      FN_TRANSLATE: begin
        if (col == 2'd3) begin
          case (k)
            2'd0:    rhs = x_q;
            2'd1:    rhs = y_q;
            2'd2:    rhs = z_q;
            default: rhs = ONE;
          endcase
        end else if (k == col) begin
          rhs = ONE;
        end
      end
      FN_SCALE: begin
        if (k == col) begin
          case (k)
            2'd0:    rhs = x_q;
            2'd1:    rhs = y_q;
            2'd2:    rhs = z_q;
            default: rhs = ONE;
          endcase
        end
      end
      FN_POINT, FN_VECTOR: begin
        case (k)
          2'd0:    rhs = x_q;
          2'd1:    rhs = y_q;
          2'd2:    rhs = z_q;
          default: rhs = (func_q == FN_POINT) ? ONE : '0;
        endcase
      end
      default: rhs = '0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_RUN) begin
        step <= step + 4'd1;
      end else begin
        step <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (func_in inside {FN_LOAD_CUR, FN_LOAD_OPND, FN_IDENTITY}) begin
            state_next = S_PUSH;
          end else begin
            state_next = S_RUN;
          end
        end
      end
      S_RUN:   if (step == last_step) state_next = S_WAIT;
      S_WAIT:  state_next = S_PUSH;
      S_PUSH:  if (can_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready             = (state == S_IDLE);
    lane_ctrl            = '0;
    lane_ctrl.load       = accept && (func_in == FN_LOAD_CUR);
    lane_ctrl.load_row   = element_index[1:0];
    lane_ctrl.load_col   = element_index[3:2];
    lane_ctrl.ident      = accept && (func_in == FN_IDENTITY);
    lane_ctrl.commit     = (state == S_PUSH) && can_load && is_matrix;
    lane_ctrl.mac_valid  = (state == S_RUN);
    lane_ctrl.first_k    = (k == 2'd0);
    lane_ctrl.first_item = (step == '0);
    lane_ctrl.last_k     = (k == 2'd3);
    lane_ctrl.k          = k;
    lane_ctrl.col        = col;
    merge_ctrl.push      = (state == S_PUSH) && can_load;
    merge_ctrl.xform     = is_xform;
    merge_ctrl.mac       = is_mac;
  end

  for (genvar r = 0; r < LANES; r++) begin : g_lane
    amtu_lane #(
      .FRAC_BITS (FRAC_BITS),
      .ROW       (r)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (lane_ctrl),
      .load_value (element_value),
      .one_value  (ONE),
      .rhs        (rhs),
      .acc        (lane_acc[r]),
      .ovf        (lane_ovf[r])
    );
  end

  amtu_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (merge_ctrl),
    .lane_acc  (lane_acc),
    .lane_ovf  (lane_ovf),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_z     (res_z),
    .overflow  (overflow)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    merge_ctrl.push |-> (!out_valid || out_ready))
    else $error("result pushed into a full output register");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (step <= last_step))
    else $error("step counter ran past the last step");

  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    (accept && ((func_in == FN_LOAD_CUR) || (func_in == FN_LOAD_OPND) ||
                (func_in == FN_IDENTITY))) |=> (state == S_PUSH))
    else $error("load transaction did not go straight to output");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_PUSH))
    else $error("output became valid outside the push state");

endmodule
`default_nettype wire

// ===== sim/tb_affine_matrix_transform_unit.sv =====
// self-checking testbench for the affine matrix transform unit with a fixed-point predictor
`default_nettype none
module tb_affine_matrix_transform_unit
  import amtu_pkg::*;
();

  localparam int unsigned FRAC          = 16;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_STALL    = 300;
  localparam int unsigned RANDOM_ITEMS  = 400;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t matrix_t [16];

  localparam word_t Q_ONE = 32'sh0001_0000;

  typedef struct packed {
    word_t rx;
    word_t ry;
    word_t rz;
    logic  ovf;
  } xyz_t;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  func_t      func          = FN_LOAD_CUR;
  logic [3:0] element_index = '0;
  word_t      element_value = '0;
  word_t      coord_x       = '0;
  word_t      coord_y       = '0;
  word_t      coord_z       = '0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  word_t      res_x;
  word_t      res_y;
  word_t      res_z;
  logic       overflow;

  matrix_t     cur_m  = '{default: '0};
  matrix_t     opnd_m = '{default: '0};
  bit          sat_hit;
  xyz_t        pending_xyz[$];
  int unsigned mismatches    = 0;
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 51;
  int unsigned stall_asked   = 0;
  int unsigned stall_served  = 0;
  int unsigned stall_left    = 0;

  affine_matrix_transform_unit #(.FRAC_BITS(FRAC)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .element_index(element_index),
    .element_value(element_value),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .coord_z(coord_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res_x(res_x),
    .res_y(res_y),
    .res_z(res_z),
    .overflow(overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_affine_matrix_transform_unit failed");
    $finish;
  end

  function automatic word_t q_sat(logic signed [63:0] v);
    if (v > 64'(WORD_MAX)) begin
      sat_hit = 1'b1;
      return WORD_MAX;
    end
    if (v < 64'(WORD_MIN)) begin
      sat_hit = 1'b1;
      return WORD_MIN;
    end
    return word_t'(v);
  endfunction

  function automatic word_t q_mul(word_t a, word_t b);
    logic signed [63:0] wa, wb;
    wa = a;
    wb = b;
    return q_sat((wa * wb) >>> FRAC);
  endfunction

  function automatic word_t q_add(word_t a, word_t b);
    logic signed [63:0] wa, wb;
    wa = a;
    wb = b;
    return q_sat(wa + wb);
  endfunction

  function automatic void compose(input matrix_t rhs);
    matrix_t prod;
    word_t   acc;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = q_mul(cur_m[r], rhs[c*4]);
        for (int k = 1; k < 4; k++) begin
          acc = q_add(acc, q_mul(cur_m[k*4+r], rhs[c*4+k]));
        end
        prod[c*4+r] = acc;
      end
    end
    cur_m = prod;
  endfunction

  function automatic word_t xform_row(int r, word_t x, word_t y, word_t z, bit with_w);
    word_t acc;
    acc = q_mul(cur_m[r], x);
    acc = q_add(acc, q_mul(cur_m[4+r], y));
    acc = q_add(acc, q_mul(cur_m[8+r], z));
    if (with_w) begin
      acc = q_add(acc, cur_m[12+r]);
    end
    return acc;
  endfunction

  // updates the matrices and returns the result that this transaction produces
  function automatic xyz_t apply_func(func_t f, logic [3:0] idx, word_t val,
                                      word_t x, word_t y, word_t z);
    matrix_t rhs;
    xyz_t    res;
    rhs     = '{default: '0};
    res     = '0;
    sat_hit = 1'b0;
    case (f)
      FN_LOAD_CUR: begin
        cur_m[idx] = val;
      end
      FN_LOAD_OPND: begin
        opnd_m[idx] = val;
      end
      FN_IDENTITY: begin
        cur_m     = '{default: '0};
        cur_m[0]  = Q_ONE;
        cur_m[5]  = Q_ONE;
        cur_m[10] = Q_ONE;
        cur_m[15] = Q_ONE;
      end
      FN_MULTIPLY: begin
        compose(opnd_m);
      end
      FN_TRANSLATE: begin
        rhs[0]  = Q_ONE;
        rhs[5]  = Q_ONE;
        rhs[10] = Q_ONE;
        rhs[15] = Q_ONE;
        rhs[12] = x;
        rhs[13] = y;
        rhs[14] = z;
        compose(rhs);
      end
      FN_SCALE: begin
        rhs[0]  = x;
        rhs[5]  = y;
        rhs[10] = z;
        rhs[15] = Q_ONE;
        compose(rhs);
      end
      default: begin
        res.rx = xform_row(0, x, y, z, f == FN_POINT);
        res.ry = xform_row(1, x, y, z, f == FN_POINT);
        res.rz = xform_row(2, x, y, z, f == FN_POINT);
      end
    endcase
    res.ovf = sat_hit;
    return res;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2, 3: return word_t'($urandom());
      default: return word_t'($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  task automatic send_item(input func_t f, input logic [3:0] idx, input word_t val,
                           input word_t x, input word_t y, input word_t z);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    func          <= f;
    element_index <= idx;
    element_value <= val;
    coord_x       <= x;
    coord_y       <= y;
    coord_z       <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_xyz.push_back(apply_func(f, idx, val, x, y, z));
  endtask

  task automatic send_random_item();
    func_t       f;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 22)      f = FN_LOAD_OPND;
    else if (pick < 36) f = FN_LOAD_CUR;
    else if (pick < 40) f = FN_IDENTITY;
    else if (pick < 48) f = FN_MULTIPLY;
    else if (pick < 55) f = FN_TRANSLATE;
    else if (pick < 62) f = FN_SCALE;
    else if (pick < 82) f = FN_POINT;
    else                f = FN_VECTOR;
    send_item(f, 4'($urandom_range(15)), rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  task automatic check_field(input string name, input word_t want, input word_t got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // receiver: random idling, plus a long hold-off on request
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_served != stall_asked) begin
      out_ready    <= 1'b0;
      stall_served <= stall_asked;
      stall_left   <= LONG_STALL;
    end else begin
      out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    xyz_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_xyz.size() == 0) begin
        $error("unexpected transaction: res_x %0d res_y %0d res_z %0d overflow %0b",
               res_x, res_y, res_z, overflow);
        mismatches++;
      end else begin
        want = pending_xyz.pop_front();
        check_field("res_x", want.rx, res_x);
        check_field("res_y", want.ry, res_y);
        check_field("res_z", want.rz, res_z);
        check_field("overflow", word_t'(want.ovf), word_t'(overflow));
      end
    end
  end

  task automatic test_zero_state();
    send_item(FN_POINT, 4'd0, '0, WORD_MAX, WORD_MIN, Q_ONE);
    send_item(FN_VECTOR, 4'd15, WORD_MIN, WORD_MIN, WORD_MAX, -Q_ONE);
  endtask

  task automatic test_identity_and_loads();
    send_item(FN_IDENTITY, 4'd0, '0, '0, '0, '0);
    send_item(FN_POINT, 4'd0, '0, 32'sh0001_8000, -32'sh0002_0000, WORD_MIN);
    // product of minus one lsb by one lsb rounds down
    send_item(FN_LOAD_CUR, 4'd0, -32'sd1, '0, '0, '0);
    send_item(FN_VECTOR, 4'd0, '0, 32'sd1, 32'sd1, -32'sd1);
    send_item(FN_LOAD_CUR, 4'd12, WORD_MAX, '0, '0, '0);
    send_item(FN_LOAD_CUR, 4'd15, WORD_MIN, '0, '0, '0);
    send_item(FN_POINT, 4'd0, '0, Q_ONE, '0, '0);
  endtask

  task automatic test_composition();
    send_item(FN_IDENTITY, 4'd0, '0, '0, '0, '0);
    send_item(FN_TRANSLATE, 4'd0, '0, WORD_MAX, WORD_MIN, 32'sh0003_0000);
    send_item(FN_POINT, 4'd0, '0, Q_ONE, -Q_ONE, '0);
    send_item(FN_VECTOR, 4'd0, '0, Q_ONE, -Q_ONE, '0);
    send_item(FN_SCALE, 4'd0, '0, WORD_MAX, WORD_MIN, '0);
    send_item(FN_LOAD_OPND, 4'd0, WORD_MIN, '0, '0, '0);
    send_item(FN_LOAD_OPND, 4'd5, WORD_MAX, '0, '0, '0);
    send_item(FN_LOAD_OPND, 4'd10, 32'sh0002_0000, '0, '0, '0);
    send_item(FN_LOAD_OPND, 4'd15, -Q_ONE, '0, '0, '0);
    send_item(FN_MULTIPLY, 4'd0, '0, '0, '0, '0);
    send_item(FN_POINT, 4'd0, '0, WORD_MAX, WORD_MAX, WORD_MAX);
    send_item(FN_VECTOR, 4'd0, '0, WORD_MIN, WORD_MIN, WORD_MIN);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_asked++;
    repeat (40) send_random_item();
  endtask

  task automatic test_random(input int unsigned n, input int unsigned s_pct,
                             input int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    send_item(FN_IDENTITY, 4'd0, '0, '0, '0, '0);
    repeat (n) send_random_item();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_zero_state();
    test_identity_and_loads();
    test_composition();
    test_backpressure();
    test_random(RANDOM_ITEMS / 3, 25, 51);
    test_random(RANDOM_ITEMS / 3, 51, 25);
    test_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_xyz.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_affine_matrix_transform_unit passed");
    end else begin
      $display("tb_affine_matrix_transform_unit failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/amtu_pkg.sv
design/amtu_lane.sv
design/amtu_merge.sv
design/affine_matrix_transform_unit.sv
sim/tb_affine_matrix_transform_unit.sv
